>>> design/stwe_pkg.sv
// Shared types and constants for the session table with expiry.
package stwe_pkg;

   localparam int SLOTS_DEFAULT = 256;
   localparam int KEY_W         = 256;
   localparam int TIME_W        = 64;
   localparam int CNT_W         = 9;
   localparam int TMO_W         = 32;
   localparam int USEC_W        = 20;
   localparam int LIFE_W        = TMO_W + USEC_W;
   localparam int CSR_AW        = 3;

   localparam logic [TMO_W-1:0]  DEFAULT_TIMEOUT = 32'd3600;
   localparam logic [USEC_W-1:0] US_PER_SECOND   = 20'd1000000;

   // word select bit of paddr (byte address 4*i)
   localparam logic REG_TIMEOUT = 1'b0;

   typedef enum logic [2:0] {
      CMD_CREATE     = 3'd0,
      CMD_VALIDATE   = 3'd1,
      CMD_REFRESH    = 3'd2,
      CMD_INVALIDATE = 3'd3,
      CMD_SWEEP      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [TIME_W-1:0] key_word0;
      logic [TIME_W-1:0] key_word1;
      logic [TIME_W-1:0] key_word2;
      logic [TIME_W-1:0] key_word3;
      logic [TIME_W-1:0] now_us;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             is_valid;
      logic [CNT_W-1:0] removed_count;
      logic [CNT_W-1:0] active_count;
   } rsp_type;

   // slot memory write controls
   typedef struct packed {
      logic              key_en;
      logic              exp_en;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] expiry;
   } mem_wr_type;

endpackage

>>> design/stwe_slot_mem.sv
// Slot storage: identifier and expiry memories, one read and one write port.
module stwe_slot_mem
   import stwe_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                     clock,
   input  logic [$clog2(SLOTS)-1:0] rd_idx,
   input  logic [$clog2(SLOTS)-1:0] wr_idx,
   input  mem_wr_type               wr,
   output logic [KEY_W-1:0]         rd_key,
   output logic [TIME_W-1:0]        rd_expiry
);

   logic [KEY_W-1:0]  key_mem [SLOTS];
   logic [TIME_W-1:0] exp_mem [SLOTS];
   logic [KEY_W-1:0]  rd_key_ff;
   logic [TIME_W-1:0] rd_exp_ff;

   always_ff @(posedge clock) begin
      if (wr.key_en) begin
         key_mem[wr_idx] <= wr.key;
      end
      if (wr.exp_en) begin
         exp_mem[wr_idx] <= wr.expiry;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_idx];
      rd_exp_ff <= exp_mem[rd_idx];
   end

   assign rd_key    = rd_key_ff;
   assign rd_expiry = rd_exp_ff;

endmodule

>>> design/session_table_with_expiry.sv
// Top level of the session table with expiry: sequencer, slot flags and CSR.
//
//  channel  | handshake                  | payload          | direction
//  req      | req_valid / req_ready      | req_data (req)   | in
//  rsp      | rsp_valid / rsp_ready      | rsp_data (rsp)   | out
//  csr      | psel/penable/pwrite/pready | paddr/pwdata/prd | in/out (APB)
//
// Every transaction runs from accept through the scan, which reads one
// slot per cycle through the single read port of the slot memory, then
// through a drain and a commit state, before the next accept. The result
// is held until taken; a new request can be accepted while it waits, and
// the commit of that one stalls until the output register is free.
// Reset (synchronous) clears all active flags, the live count and the
// timeout register (3600); key and expiry memories are not cleared.
module session_table_with_expiry
   import stwe_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   // APB configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [TMO_W-1:0]  pwdata,
   output logic [TMO_W-1:0]  prdata,
   output logic              pready
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   // ---------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------
   logic [TMO_W-1:0] timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= DEFAULT_TIMEOUT;
      end else if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT) begin
         timeout_ff <= pwdata;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_ff : '0;

   // Lifetime in microseconds: one 32x20 multiply, then one 64-bit add.
   // Both are recomputed every cycle; the user keeps the inputs stable while busy (not enforced).
   logic [TMO_W-1:0]  tmo_eff;
   logic [LIFE_W-1:0] life_prod;
   logic [TIME_W-1:0] lifetime_ff;
   logic [TIME_W-1:0] new_exp_ff;

   assign tmo_eff   = (timeout_ff == '0) ? DEFAULT_TIMEOUT : timeout_ff;
   assign life_prod = LIFE_W'(tmo_eff) * LIFE_W'(US_PER_SECOND);

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   state_type state_ff, state_in;
   logic      commit_go;
   logic      rsp_valid_ff;
   logic      last_issue;

   logic [IW-1:0]     scan_idx_ff;
   logic [2:0]        cmd_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [TIME_W-1:0] now_ff;

   assign last_issue = (scan_idx_ff == IW'(SLOTS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      commit_go = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (last_issue) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               commit_go = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lifetime_ff <= TIME_W'(life_prod);
      new_exp_ff  <= now_ff + lifetime_ff;
      if (req_valid && req_ready) begin
         cmd_ff <= req_data.cmd;
         key_ff <= {req_data.key_word3, req_data.key_word2,
                    req_data.key_word1, req_data.key_word0};
         now_ff <= req_data.now_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
      end else if (req_valid && req_ready) begin
         scan_idx_ff <= '0;
      end else if (state_ff == S_SCAN && !last_issue) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Slot memory and active flags
   // ---------------------------------------------------------------
   logic [SLOTS-1:0]  active_ff;
   logic [KEY_W-1:0]  mem_key;
   logic [TIME_W-1:0] mem_expiry;
   mem_wr_type        mem_wr;
   logic [IW-1:0]     hit_idx_ff;

   stwe_slot_mem #(
      .SLOTS(SLOTS)
   ) u_slot_mem (
      .clock    (clock),
      .rd_idx   (scan_idx_ff),
      .wr_idx   (hit_idx_ff),
      .wr       (mem_wr),
      .rd_key   (mem_key),
      .rd_expiry(mem_expiry)
   );

   // evaluation stage: lines up with the registered memory read
   logic          ev_vld_ff;
   logic          ev_act_ff;
   logic [IW-1:0] ev_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_vld_ff <= 1'b0;
      end else begin
         ev_vld_ff <= (state_ff == S_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff <= scan_idx_ff;
      ev_act_ff <= active_ff[scan_idx_ff];
   end

   // shared compare unit: now >= expiry, plus the key equality
   logic is_create, is_validate, is_refresh, is_inval, is_sweep, is_lookup;
   logic exp_ge, key_eq, cand, take, sweep_kill;
   logic hit_ff, hit_ge_ff;
   logic [CW-1:0] removed_ff;
   logic [CW-1:0] live_ff, live_in;

   assign is_create   = (cmd_ff == CMD_CREATE);
   assign is_validate = (cmd_ff == CMD_VALIDATE);
   assign is_refresh  = (cmd_ff == CMD_REFRESH);
   assign is_inval    = (cmd_ff == CMD_INVALIDATE);
   assign is_sweep    = (cmd_ff == CMD_SWEEP);
   assign is_lookup   = is_validate || is_refresh || is_inval;

   assign exp_ge     = (now_ff >= mem_expiry);
   assign key_eq     = (mem_key == key_ff);
   assign cand       = is_create ? !ev_act_ff : (is_lookup && ev_act_ff && key_eq);
   assign take       = ev_vld_ff && cand && !hit_ff;
   assign sweep_kill = ev_vld_ff && is_sweep && ev_act_ff && exp_ge;

   // first free slot (create) or first matching active slot (lookups)
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         hit_ff <= 1'b0;
      end else if (take) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hit_idx_ff <= ev_idx_ff;
         hit_ge_ff  <= exp_ge;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         removed_ff <= '0;
      end else if (req_valid && req_ready) begin
         removed_ff <= '0;
      end else if (sweep_kill) begin
         removed_ff <= removed_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (sweep_kill) begin
         active_ff[ev_idx_ff] <= 1'b0;
      end else if (commit_go && hit_ff && is_create) begin
         active_ff[hit_idx_ff] <= 1'b1;
      end else if (commit_go && hit_ff && is_inval) begin
         active_ff[hit_idx_ff] <= 1'b0;
      end
   end

   always_comb begin
      live_in = live_ff;
      if (sweep_kill) begin
         live_in = live_ff - 1'b1;
      end else if (commit_go && hit_ff && is_create) begin
         live_in = live_ff + 1'b1;
      end else if (commit_go && hit_ff && is_inval) begin
         live_in = live_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   assign mem_wr.key_en = commit_go && hit_ff && is_create;
   assign mem_wr.exp_en = commit_go && hit_ff && (is_create || is_refresh);
   assign mem_wr.key    = key_ff;
   assign mem_wr.expiry = new_exp_ff;

   // ---------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------
   rsp_type    rsp_ff;
   status_type status_in;

   always_comb begin
      case (cmd_ff)
         CMD_CREATE:     status_in = hit_ff ? ST_OK : ST_FULL;
         CMD_VALIDATE,
         CMD_REFRESH,
         CMD_INVALIDATE: status_in = hit_ff ? ST_OK : ST_MISSING;
         default:        status_in = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_go) begin
         rsp_ff.status        <= status_in;
         rsp_ff.is_valid      <= is_validate && hit_ff && !hit_ge_ff;
         rsp_ff.removed_count <= CNT_W'(removed_ff);
         rsp_ff.active_count  <= CNT_W'(live_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_SCAN && scan_idx_ff == '0))
      else $error("scan did not start at slot zero after accept");

   a_live_bounded: assert property (@(posedge clock) disable iff (reset)
      (32'(removed_ff) + 32'(live_ff)) <= 32'(SLOTS))
      else $error("freed plus live sessions exceed table size");

   a_create_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (commit_go && hit_ff && is_create) |=> active_ff[$past(hit_idx_ff)])
      else $error("created slot not marked active");

   a_eval_in_scan: assert property (@(posedge clock) disable iff (reset)
      ev_vld_ff |-> (state_ff == S_SCAN || state_ff == S_DRAIN))
      else $error("slot evaluation outside of scan");

endmodule
